@@ rtl/core/srct_pkg.sv @@
// Shared types, constants and helpers for the request coalescing table.
`default_nettype none
package srct_pkg;

	localparam int TABLE_SLOTS = 16;
	localparam int SLOT_W      = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
	localparam int IDX_W       = $clog2(TABLE_SLOTS + 1);

	localparam int KEY_W     = 36;
	localparam int PAGE_W    = 16;
	localparam int PRIO_W    = 8;
	localparam int DUE_W     = 32;
	localparam int OWNER_W   = 56;
	localparam int PAYLOAD_W = 60;

	localparam logic [1:0] CMD_PUBLISH = 2'd0;
	localparam logic [1:0] CMD_RELEASE = 2'd1;
	localparam logic [1:0] CMD_CLEAR   = 2'd2;

	localparam logic [1:0] ST_INSERTED = 2'd0;
	localparam logic [1:0] ST_MERGED   = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;
	localparam logic [1:0] ST_RELEASED = 2'd3;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_SCAN,
		FSM_WRITE,
		FSM_RESP
	} fsm_t;

	typedef struct packed {
		logic [KEY_W-1:0]   key;
		logic [PAGE_W-1:0]  page;
		logic [PRIO_W-1:0]  prio;
		logic [DUE_W-1:0]   due;
		logic [OWNER_W-1:0] owner;
	} slot_entry_t;

	typedef struct packed {
		logic              en;
		logic              full;   // insert: also write payload
		logic [SLOT_W-1:0] addr;
	} store_wr_t;

	typedef struct packed {
		logic               hit;
		logic [PRIO_W-1:0]  prio;
		logic [DUE_W-1:0]   due;
		logic [OWNER_W-1:0] owner;
	} merge_res_t;

	// slot number as shown on the 4-bit slot port
	function automatic logic [3:0] slot_out(input logic [SLOT_W-1:0] idx);
		logic [SLOT_W+3:0] ext;
		ext = {4'b0000, idx};
		return ext[3:0];
	endfunction

endpackage
`default_nettype wire

@@ rtl/core/srct_store.sv @@
// Slot storage: entry and payload memories, one write port, registered read.
`default_nettype none
module srct_store (
	input  wire logic                                clk,
	input  wire srct_pkg::store_wr_t                 wr,
	input  wire srct_pkg::slot_entry_t               wr_entry,
	input  wire logic [srct_pkg::PAYLOAD_W-1:0]      wr_payload,
	input  wire logic [srct_pkg::SLOT_W-1:0]         rd_addr,
	output srct_pkg::slot_entry_t                    rd_entry
);

	srct_pkg::slot_entry_t               entry_mem [srct_pkg::TABLE_SLOTS];
	logic [srct_pkg::PAYLOAD_W-1:0]      payload_mem [srct_pkg::TABLE_SLOTS];
	srct_pkg::slot_entry_t               rd_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			entry_mem[wr.addr] <= wr_entry;
			if (wr.full) begin
				payload_mem[wr.addr] <= wr_payload;
			end
		end
		rd_q <= entry_mem[rd_addr];
	end

	assign rd_entry = rd_q;

endmodule
`default_nettype wire

@@ rtl/core/srct_merge.sv @@
// Shared compare unit: key/page match and merged priority, deadline, owner.
`default_nettype none
module srct_merge (
	input  wire srct_pkg::slot_entry_t               entry,
	input  wire logic [srct_pkg::KEY_W-1:0]          key,
	input  wire logic [srct_pkg::PAGE_W-1:0]         page,
	input  wire logic [srct_pkg::PRIO_W-1:0]         prio,
	input  wire logic [srct_pkg::DUE_W-1:0]          due,
	input  wire logic [srct_pkg::OWNER_W-1:0]        owner,
	output srct_pkg::merge_res_t                     res
);

	logic take_owner;

	always_comb begin
		// owner kind 0 means no owner
		take_owner = (owner[3:0] != 4'd0) &&
			((entry.owner[3:0] == 4'd0) || (due <= entry.due));
		res.hit   = (entry.key == key) && (entry.page == page);
		res.prio  = (prio > entry.prio) ? prio : entry.prio;
		res.due   = (due < entry.due) ? due : entry.due;
		res.owner = take_owner ? owner : entry.owner;
	end

endmodule
`default_nettype wire

@@ rtl/core/stream_request_coalescing_table.sv @@
// Top level: sequencer, active bits and result register of the coalescing table.
`default_nettype none
// Request coalescing table of srct_pkg::TABLE_SLOTS slots. A publish
// transaction scans the slots one per cycle through a single compare unit
// against a registered-read slot memory. An insert goes through the scan,
// the write state and the result state; a full table skips the write state
// and answers sooner, and a hit in slot n ends the scan at that slot.
// Release and clear transactions go straight to the result state; command 3 is
// taken and gives no result. in_stall stays high while a transaction is in
// work and drops the cycle after its result is loaded. A finished result sits
// in the output register until taken; a new transaction may be accepted
// meanwhile. Active bits reset to empty; no clearing pass is needed.
module stream_request_coalescing_table (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  cmd,
	input  wire logic [3:0]  domain,
	input  wire logic [31:0] obj_id,
	input  wire logic [15:0] page_num,
	input  wire logic [7:0]  priority_req,
	input  wire logic [31:0] deadline,
	input  wire logic [55:0] owner_record,
	input  wire logic [31:0] created_frame,
	input  wire logic [31:0] reg_epoch,
	input  wire logic [27:0] geometry,
	input  wire logic [3:0]  release_slot,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       status,
	output logic [3:0]       slot,
	output logic [7:0]       slot_priority,
	output logic [31:0]      slot_deadline,
	output logic [55:0]      slot_owner
);

	localparam int SW = srct_pkg::SLOT_W;
	localparam int IW = srct_pkg::IDX_W;

	srct_pkg::fsm_t state_q, state_d;

	logic [srct_pkg::TABLE_SLOTS-1:0] active_q;

	// latched publish item
	logic [srct_pkg::KEY_W-1:0]     key_q;
	logic [srct_pkg::PAGE_W-1:0]    page_q;
	logic [srct_pkg::PRIO_W-1:0]    prio_q;
	logic [srct_pkg::DUE_W-1:0]     due_q;
	logic [srct_pkg::OWNER_W-1:0]   owner_q;
	logic [srct_pkg::PAYLOAD_W-1:0] payload_q;
	logic [31:0]                    epoch_q;

	// scan control
	logic [IW-1:0] idx_q;
	logic          cmp_v_s1;
	logic [SW-1:0] cmp_idx_s1;
	logic          have_free_q;
	logic [SW-1:0] free_q;
	logic [SW-1:0] wr_addr_q;
	logic          wr_full_q;

	// pending result
	logic [1:0]                   res_status_q;
	logic [3:0]                   res_slot_q;
	logic [srct_pkg::PRIO_W-1:0]  res_prio_q;
	logic [srct_pkg::DUE_W-1:0]   res_due_q;
	logic [srct_pkg::OWNER_W-1:0] res_owner_q;

	logic out_valid_q;

	srct_pkg::store_wr_t   wr;
	srct_pkg::slot_entry_t wr_entry;
	srct_pkg::slot_entry_t rd_entry;
	srct_pkg::merge_res_t  mres;

	logic          accept;
	logic          issue;
	logic          cmp_hit;
	logic          cmp_free;
	logic          scan_done;
	logic          out_load;
	logic          rel_ok;
	logic [SW+3:0] rel_ext;

	assign accept    = in_valid && !in_stall;
	assign issue     = (state_q == srct_pkg::FSM_SCAN) && (idx_q != IW'(srct_pkg::TABLE_SLOTS));
	assign cmp_free  = cmp_v_s1 && !active_q[cmp_idx_s1];
	assign cmp_hit   = cmp_v_s1 && active_q[cmp_idx_s1] && mres.hit;
	assign scan_done = (state_q == srct_pkg::FSM_SCAN) && !cmp_v_s1 && !issue;
	assign out_load  = (state_q == srct_pkg::FSM_RESP) && (!out_valid_q || !out_stall);
	assign rel_ext   = {{SW{1'b0}}, release_slot};
	assign rel_ok    = {5'd0, release_slot} < 9'(srct_pkg::TABLE_SLOTS);

	assign wr.en   = (state_q == srct_pkg::FSM_WRITE);
	assign wr.full = wr_full_q;
	assign wr.addr = wr_addr_q;
	assign wr_entry.key   = key_q;
	assign wr_entry.page  = page_q;
	assign wr_entry.prio  = res_prio_q;
	assign wr_entry.due   = res_due_q;
	assign wr_entry.owner = res_owner_q;

	srct_store u_store (
		.clk        (clk),
		.wr         (wr),
		.wr_entry   (wr_entry),
		.wr_payload (payload_q),
		.rd_addr    (idx_q[SW-1:0]),
		.rd_entry   (rd_entry)
	);

	srct_merge u_merge (
		.entry (rd_entry),
		.key   (key_q),
		.page  (page_q),
		.prio  (prio_q),
		.due   (due_q),
		.owner (owner_q),
		.res   (mres)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= srct_pkg::FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_stall = (state_q != srct_pkg::FSM_IDLE);
		case (state_q)
			srct_pkg::FSM_IDLE: begin
				if (in_valid) begin
					case (cmd)
						srct_pkg::CMD_PUBLISH: state_d = srct_pkg::FSM_SCAN;
						srct_pkg::CMD_RELEASE,
						srct_pkg::CMD_CLEAR:   state_d = srct_pkg::FSM_RESP;
						default:               state_d = srct_pkg::FSM_IDLE;
					endcase
				end
			end
			srct_pkg::FSM_SCAN: begin
				if (cmp_hit) begin
					state_d = srct_pkg::FSM_WRITE;
				end else if (scan_done) begin
					state_d = have_free_q ? srct_pkg::FSM_WRITE : srct_pkg::FSM_RESP;
				end
			end
			srct_pkg::FSM_WRITE: state_d = srct_pkg::FSM_RESP;
			srct_pkg::FSM_RESP: begin
				if (out_load) begin
					state_d = srct_pkg::FSM_IDLE;
				end
			end
			default: state_d = srct_pkg::FSM_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= '0;
			idx_q       <= '0;
			cmp_v_s1    <= 1'b0;
			have_free_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				idx_q       <= '0;
				cmp_v_s1    <= 1'b0;
				have_free_q <= 1'b0;
				if (cmd == srct_pkg::CMD_RELEASE && rel_ok) begin
					active_q[rel_ext[SW-1:0]] <= 1'b0;
				end else if (cmd == srct_pkg::CMD_CLEAR) begin
					active_q <= '0;
				end
			end else begin
				if (issue) begin
					idx_q <= idx_q + IW'(1);
				end
				cmp_v_s1 <= issue && !cmp_hit;
				if (cmp_free) begin
					have_free_q <= 1'b1;
				end
			end
			if (wr.en && wr_full_q) begin
				active_q[wr_addr_q] <= 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q     <= {domain, obj_id};
			page_q    <= page_num;
			prio_q    <= priority_req;
			due_q     <= deadline;
			owner_q   <= owner_record;
			payload_q <= {created_frame, geometry};
			epoch_q   <= reg_epoch;
			res_status_q <= srct_pkg::ST_RELEASED;
			res_slot_q   <= (cmd == srct_pkg::CMD_RELEASE) ? release_slot : 4'd0;
			res_prio_q   <= '0;
			res_due_q    <= '0;
			res_owner_q  <= '0;
		end
		cmp_idx_s1 <= idx_q[SW-1:0];
		// lowest free slot: first inactive one seen in scan order
		if (cmp_free && !have_free_q) begin
			free_q <= cmp_idx_s1;
		end
		if (cmp_hit) begin
			wr_addr_q    <= cmp_idx_s1;
			wr_full_q    <= 1'b0;
			res_status_q <= srct_pkg::ST_MERGED;
			res_slot_q   <= srct_pkg::slot_out(cmp_idx_s1);
			res_prio_q   <= mres.prio;
			res_due_q    <= mres.due;
			res_owner_q  <= mres.owner;
		end else if (scan_done) begin
			wr_addr_q <= free_q;
			wr_full_q <= 1'b1;
			if (have_free_q) begin
				res_status_q <= srct_pkg::ST_INSERTED;
				res_slot_q   <= srct_pkg::slot_out(free_q);
				res_prio_q   <= prio_q;
				res_due_q    <= due_q;
				res_owner_q  <= owner_q;
			end else begin
				res_status_q <= srct_pkg::ST_FULL;
				res_slot_q   <= 4'd0;
				res_prio_q   <= '0;
				res_due_q    <= '0;
				res_owner_q  <= '0;
			end
		end
		if (out_load) begin
			status        <= res_status_q;
			slot          <= res_slot_q;
			slot_priority <= res_prio_q;
			slot_deadline <= res_due_q;
			slot_owner    <= res_owner_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire
